@@ hdl/rgbyuv_pkg.sv @@
// Shared types, codes and constants of the RGB / YUV 4:2:0 color converter.
// Used by every module of the block; depends on nothing else.
package rgbyuv_pkg;

  localparam int CFG_W          = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int BYTE_W         = 8;
  localparam int ADDR_W         = 25;
  localparam int LUMA_W         = 24;
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

  localparam logic MODE_TO_YUV = 1'b0;
  localparam logic MODE_TO_RGB = 1'b1;

  localparam logic LAYOUT_NV21 = 1'b0;
  localparam logic LAYOUT_I420 = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_CHROMA_LAYOUT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_LUMA = 2'd0,
    KIND_V    = 2'd1,
    KIND_U    = 2'd2,
    KIND_RGB  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_LUMA = 2'd0,
    ST_V    = 2'd1,
    ST_U    = 2'd2
  } seq_state_e;

  // One classified input item as it waits in the queue.
  typedef struct packed {
    logic              mode;
    logic              chroma;
    logic [BYTE_W-1:0] c0;
    logic [BYTE_W-1:0] c1;
    logic [BYTE_W-1:0] c2;
  } pix_t;

endpackage

@@ hdl/rgbyuv_front.sv @@
// Front end: configuration registers, input acceptance, frame position counters
// and chroma classification. Depends on rgbyuv_pkg.
module rgbyuv_front
  import rgbyuv_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [BYTE_W-1:0]    in_red_or_luma,
  input  logic [BYTE_W-1:0]    in_green_or_u,
  input  logic [BYTE_W-1:0]    in_blue_or_v,
  input  logic                 q_full,
  output logic                 q_push,
  output pix_t                 q_pix,
  output logic [CW-1:0]        q_col,
  output logic [RW-1:0]        q_row,
  output logic [LUMA_W-1:0]    q_luma,
  output logic [WW-1:0]        w_sat,
  output logic [HW-1:0]        h_sat,
  output logic                 layout
);

  logic [CFG_W-1:0]  width_r, width_nxt;
  logic [CFG_W-1:0]  height_r, height_nxt;
  logic              layout_r, layout_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [LUMA_W-1:0] luma_r, luma_nxt;
  logic [CW:0]       col_inc;
  logic [RW:0]       row_inc;
  logic              col_wrap, row_wrap;

  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    layout_nxt = layout_r;
    if (cfg_valid) begin
      case (cfg_reg_e'(cfg_index))
        REG_FRAME_WIDTH:   width_nxt  = cfg_data;
        REG_FRAME_HEIGHT:  height_nxt = cfg_data;
        REG_CHROMA_LAYOUT: layout_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sizes outside the supported range are pinned to its ends.
  always_comb begin
    if (32'(width_r) < 32'd2) begin
      w_sat = WW'(2);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(width_r);
    end
    if (32'(height_r) < 32'd2) begin
      h_sat = HW'(2);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_sat = HW'(MAX_HEIGHT);
    end else begin
      h_sat = HW'(height_r);
    end
  end

  assign layout   = layout_r;
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign q_pix.mode   = in_mode;
  assign q_pix.chroma = !row_r[0] && !col_r[0];
  assign q_pix.c0     = in_red_or_luma;
  assign q_pix.c1     = in_green_or_u;
  assign q_pix.c2     = in_blue_or_v;
  assign q_col        = col_r;
  assign q_row        = row_r;
  assign q_luma       = luma_r;

  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign col_wrap = col_inc >= (CW + 1)'(w_sat);
  assign row_wrap = row_inc >= (RW + 1)'(h_sat);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    luma_nxt = luma_r;
    if (q_push && in_mode == MODE_TO_YUV) begin
      luma_nxt = luma_r + 1'b1;
      if (col_wrap) begin
        col_nxt = '0;
        if (row_wrap) begin
          row_nxt  = '0;
          luma_nxt = '0;
        end else begin
          row_nxt = row_inc[RW-1:0];
        end
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_FRAME_WIDTH;
      height_r <= RESET_FRAME_HEIGHT;
      layout_r <= LAYOUT_NV21;
      col_r    <= '0;
      row_r    <= '0;
      luma_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      layout_r <= layout_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      luma_r   <= luma_nxt;
    end
  end

endmodule

@@ hdl/rgbyuv_queue.sv @@
// Small register-based FIFO that decouples the front end from the back end.
// Depends on rgbyuv_pkg for the default depth.
module rgbyuv_queue
  import rgbyuv_pkg::*;
#(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full       = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ hdl/rgbyuv_back.sv @@
// Back end: color arithmetic, plane address products and the result sequencer
// that drives the output register. Depends on rgbyuv_pkg.
module rgbyuv_back
  import rgbyuv_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int PW = WW + HW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  pix_t              q_pix,
  input  logic [CW-1:0]     q_col,
  input  logic [RW-1:0]     q_row,
  input  logic [LUMA_W-1:0] q_luma,
  input  logic [WW-1:0]     w_sat,
  input  logic [HW-1:0]     h_sat,
  input  logic              layout,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [ADDR_W-1:0] out_byte_address,
  output logic [BYTE_W-1:0] out_value_a,
  output logic [BYTE_W-1:0] out_value_b,
  output logic [BYTE_W-1:0] out_value_c,
  output logic              out_last
);

  function automatic logic [BYTE_W-1:0] clamp8(input logic signed [19:0] x);
    logic signed [19:0] sh;
    sh = x >>> 8;
    if (sh < 20'sd0) begin
      return '0;
    end else if (sh > 20'sd255) begin
      return 8'd255;
    end else begin
      return sh[7:0];
    end
  endfunction

  // Operands and sums of the head item.
  logic signed [19:0] ps, qs, ss, cs, us, vs;
  logic signed [19:0] ysum, usum, vsum, rsum, gsum, bsum;
  logic [BYTE_W-1:0]  b0_new, b1_new, b2_new;
  logic [WW-1:0]      wsel;
  logic [PW-1:0]      ysize_new;
  logic [RW+WW-1:0]   rowprod_new;

  // Item held by the sequencer.
  logic              y_vld_r, y_vld_nxt;
  logic              y_mode_r, y_chroma_r, y_layout_r;
  logic [BYTE_W-1:0] y_b0_r, y_b1_r, y_b2_r;
  logic [PW-1:0]     y_ysize_r;
  logic [RW+WW-1:0]  y_rowprod_r;
  logic [CW-1:0]     y_col_r;
  logic [LUMA_W-1:0] y_luma_r;
  seq_state_e        state_r, state_nxt;

  logic [ADDR_W-1:0] ysz, yqtr, rp, col_ext, colh, nv_v, nv_u, idx, i4_u, i4_v;
  logic              issue, load, final_res;
  kind_e             res_kind;
  logic [ADDR_W-1:0] res_addr;
  logic [BYTE_W-1:0] res_a, res_b, res_c;
  logic              res_last;

  logic              out_valid_r, out_valid_nxt;
  kind_e             out_kind_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [BYTE_W-1:0] out_a_r, out_b_r, out_c_r;
  logic              out_last_r;

  // Color arithmetic. In the forward direction the results always land inside
  // a byte, so only the inverse direction needs clamping.
  always_comb begin
    ps   = {12'b0, q_pix.c0};
    qs   = {12'b0, q_pix.c1};
    ss   = {12'b0, q_pix.c2};
    cs   = ps - 20'sd16;
    us   = qs - 20'sd128;
    vs   = ss - 20'sd128;
    ysum = 20'sd66 * ps + 20'sd129 * qs + 20'sd25 * ss + 20'sd128;
    usum = -20'sd38 * ps - 20'sd74 * qs + 20'sd112 * ss + 20'sd128;
    vsum = 20'sd112 * ps - 20'sd94 * qs - 20'sd18 * ss + 20'sd128;
    rsum = 20'sd298 * cs + 20'sd409 * vs + 20'sd128;
    gsum = 20'sd298 * cs - 20'sd100 * us - 20'sd208 * vs + 20'sd128;
    bsum = 20'sd298 * cs + 20'sd516 * us + 20'sd128;
    if (q_pix.mode == MODE_TO_RGB) begin
      b0_new = clamp8(rsum);
      b1_new = clamp8(gsum);
      b2_new = clamp8(bsum);
    end else begin
      b0_new = ysum[15:8] + 8'd16;
      b1_new = vsum[15:8] + 8'd128;
      b2_new = usum[15:8] + 8'd128;
    end
  end

  // NV21 rows are a full width long; planar chroma rows are half of it.
  assign wsel        = (layout == LAYOUT_I420) ? (w_sat >> 1) : w_sat;
  assign ysize_new   = PW'(w_sat) * PW'(h_sat);
  assign rowprod_new = (RW + WW)'(q_row >> 1) * (RW + WW)'(wsel);

  assign issue = y_vld_r && (!out_valid_r || out_ready);
  assign load  = !y_vld_r || (issue && final_res);
  assign q_pop = q_valid && load;

  always_comb begin
    y_vld_nxt = y_vld_r;
    if (load) begin
      y_vld_nxt = q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      y_mode_r    <= q_pix.mode;
      y_chroma_r  <= q_pix.chroma;
      y_layout_r  <= layout;
      y_b0_r      <= b0_new;
      y_b1_r      <= b1_new;
      y_b2_r      <= b2_new;
      y_ysize_r   <= ysize_new;
      y_rowprod_r <= rowprod_new;
      y_col_r     <= q_col;
      y_luma_r    <= q_luma;
    end
  end

  // Chroma plane addresses. The quarter plane comes from the unmasked size.
  always_comb begin
    ysz     = ADDR_W'(y_ysize_r);
    yqtr    = ADDR_W'(y_ysize_r >> 2);
    rp      = ADDR_W'(y_rowprod_r);
    col_ext = ADDR_W'(y_col_r);
    colh    = ADDR_W'(y_col_r >> 1);
    nv_v    = ysz + rp + col_ext;
    nv_u    = nv_v + 1'b1;
    idx     = rp + colh;
    i4_u    = ysz + idx;
    i4_v    = ysz + yqtr + idx;
  end

  // Sequencer outputs: the result for the current step of the held item.
  always_comb begin
    res_kind  = KIND_LUMA;
    res_addr  = ADDR_W'(y_luma_r);
    res_a     = y_b0_r;
    res_b     = '0;
    res_c     = '0;
    res_last  = !y_chroma_r;
    final_res = !y_chroma_r;
    if (y_mode_r == MODE_TO_RGB) begin
      res_kind  = KIND_RGB;
      res_addr  = '0;
      res_b     = y_b1_r;
      res_c     = y_b2_r;
      res_last  = 1'b1;
      final_res = 1'b1;
    end else begin
      case (state_r)
        ST_LUMA: ;
        ST_V: begin
          res_kind  = KIND_V;
          res_addr  = (y_layout_r == LAYOUT_I420) ? i4_v : nv_v;
          res_a     = y_b1_r;
          res_last  = 1'b0;
          final_res = 1'b0;
        end
        ST_U: begin
          res_kind  = KIND_U;
          res_addr  = (y_layout_r == LAYOUT_I420) ? i4_u : nv_u;
          res_a     = y_b2_r;
          res_last  = 1'b1;
          final_res = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (issue) begin
      if (final_res) begin
        state_nxt = ST_LUMA;
      end else begin
        case (state_r)
          ST_LUMA: state_nxt = ST_V;
          ST_V:    state_nxt = ST_U;
          default: state_nxt = ST_LUMA;
        endcase
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (issue) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_kind_r <= res_kind;
      out_addr_r <= res_addr;
      out_a_r    <= res_a;
      out_b_r    <= res_b;
      out_c_r    <= res_c;
      out_last_r <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_vld_r     <= 1'b0;
      state_r     <= ST_LUMA;
      out_valid_r <= 1'b0;
    end else begin
      y_vld_r     <= y_vld_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_byte_address = out_addr_r;
  assign out_value_a      = out_a_r;
  assign out_value_b      = out_b_r;
  assign out_value_c      = out_c_r;
  assign out_last         = out_last_r;

endmodule

@@ hdl/rgb_yuv420_color_converter.sv @@
// Top level of the BT.601 RGB / YUV 4:2:0 (NV21 / I420) color converter.
// Instantiates rgbyuv_front, rgbyuv_queue and rgbyuv_back; depends on rgbyuv_pkg.
//
// Usage: the in_ channel takes one transaction per pixel (mode 0, RGB in raster
// order) or per luma/U/V triple (mode 1). Each mode 0 pixel yields a luma byte
// with its frame address; pixels on an even row and even column then yield the
// V byte and the U byte. A mode 1 triple yields one clamped RGB pixel. The
// out_ channel carries one result per transaction, out_last marking the final
// result of an input transaction.
// Registers must be written by the user over the cfg_ channel (always ready)
// only while the block is idle; the block does not enforce this. Index 0 frame
// width, 1 frame height, 2 chroma layout (0 NV21, 1 I420). An item passes
// through the queue, the sequencer item register and the output register before
// its first result is valid. The back end issues one result per cycle into the
// output register while that register is empty or out_ready is high; an item
// yields one result, or three for a pixel that carries chroma. A four-entry queue
// lets the input keep taking items while results drain or out_ready is low.
// Reset clears the position counters to the frame origin, loads 640 x 480 NV21
// and empties the queue and output register. A stalled receiver holds the
// output; the queue then fills and in_ready falls.
module rgb_yuv420_color_converter
  import rgbyuv_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [BYTE_W-1:0]    in_red_or_luma,
  input  logic [BYTE_W-1:0]    in_green_or_u,
  input  logic [BYTE_W-1:0]    in_blue_or_v,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [ADDR_W-1:0]    out_byte_address,
  output logic [BYTE_W-1:0]    out_value_a,
  output logic [BYTE_W-1:0]    out_value_b,
  output logic [BYTE_W-1:0]    out_value_c,
  output logic                 out_last
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int DESC_W = $bits(pix_t) + CW + RW + LUMA_W;

  logic              q_full, q_push, q_pop, q_head_valid;
  pix_t              f_pix, b_pix;
  logic [CW-1:0]     f_col, b_col;
  logic [RW-1:0]     f_row, b_row;
  logic [LUMA_W-1:0] f_luma, b_luma;
  logic [DESC_W-1:0] q_in, q_out;
  logic [WW-1:0]     w_sat;
  logic [HW-1:0]     h_sat;
  logic              layout;

  rgbyuv_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_red_or_luma (in_red_or_luma),
    .in_green_or_u  (in_green_or_u),
    .in_blue_or_v   (in_blue_or_v),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_pix          (f_pix),
    .q_col          (f_col),
    .q_row          (f_row),
    .q_luma         (f_luma),
    .w_sat          (w_sat),
    .h_sat          (h_sat),
    .layout         (layout)
  );

  assign q_in = {f_pix, f_col, f_row, f_luma};

  rgbyuv_queue #(
    .DATA_W (DESC_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_out)
  );

  assign {b_pix, b_col, b_row, b_luma} = q_out;

  rgbyuv_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_head_valid),
    .q_pop            (q_pop),
    .q_pix            (b_pix),
    .q_col            (b_col),
    .q_row            (b_row),
    .q_luma           (b_luma),
    .w_sat            (w_sat),
    .h_sat            (h_sat),
    .layout           (layout),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_byte_address (out_byte_address),
    .out_value_a      (out_value_a),
    .out_value_b      (out_value_b),
    .out_value_c      (out_value_c),
    .out_last         (out_last)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the RGB / YUV 4:2:0 color converter.
// Depends on rgbyuv_pkg and rgb_yuv420_color_converter; predicts every result in-bench.
module tb_top;
  import rgbyuv_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_PHASES   = 10;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] ch0;
    logic [BYTE_W-1:0] ch1;
    logic [BYTE_W-1:0] ch2;
  } pixel_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] val_a;
    logic [BYTE_W-1:0] val_b;
    logic [BYTE_W-1:0] val_c;
    logic              last;
  } frame_write_t;

  typedef enum int {RX_STEADY, RX_CHOPPY, RX_SLUGGISH} rx_style_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_mode = MODE_TO_YUV;
  logic [BYTE_W-1:0]    in_red_or_luma = '0;
  logic [BYTE_W-1:0]    in_green_or_u = '0;
  logic [BYTE_W-1:0]    in_blue_or_v = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_kind;
  logic [ADDR_W-1:0]    out_byte_address;
  logic [BYTE_W-1:0]    out_value_a;
  logic [BYTE_W-1:0]    out_value_b;
  logic [BYTE_W-1:0]    out_value_c;
  logic                 out_last;

  rgb_yuv420_color_converter uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_red_or_luma(in_red_or_luma), .in_green_or_u(in_green_or_u),
    .in_blue_or_v(in_blue_or_v),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_byte_address(out_byte_address), .out_value_a(out_value_a),
    .out_value_b(out_value_b), .out_value_c(out_value_c), .out_last(out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the registers and the raster position.
  logic [CFG_W-1:0]  cur_width  = RESET_FRAME_WIDTH;
  logic [CFG_W-1:0]  cur_height = RESET_FRAME_HEIGHT;
  logic              cur_layout = LAYOUT_NV21;
  int unsigned       pos_column = 0;
  int unsigned       pos_row    = 0;
  logic [LUMA_W-1:0] luma_offset = '0;

  pixel_item_t  pixel_queue[$];
  frame_write_t expected_writes[$];
  int           pixels_queued = 0;
  int           pixels_taken  = 0;
  int           error_count   = 0;
  logic         in_taken  = 1'b0;
  logic         cfg_taken = 1'b0;

  function automatic logic [BYTE_W-1:0] clamp_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[BYTE_W-1:0];
  endfunction

  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void push_write(input kind_e k, input int unsigned addr,
                                     input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
                                     input logic [BYTE_W-1:0] c, input logic last);
    frame_write_t r;
    r.kind  = k;
    r.addr  = ADDR_W'(addr);
    r.val_a = a;
    r.val_b = b;
    r.val_c = c;
    r.last  = last;
    expected_writes.push_back(r);
  endfunction

  // Works out the results of one accepted item and advances the raster position.
  function automatic void convert_pixel(input pixel_item_t it);
    int p, q, s, c, u, v, y, r, g, b;
    int unsigned w, h, ysize, vaddr, uaddr, idx;
    logic has_chroma;
    p = it.ch0;
    q = it.ch1;
    s = it.ch2;
    if (it.mode == MODE_TO_RGB) begin
      c = p - 16;
      u = q - 128;
      v = s - 128;
      r = (298 * c + 409 * v + 128) >>> 8;
      g = (298 * c - 100 * u - 208 * v + 128) >>> 8;
      b = (298 * c + 516 * u + 128) >>> 8;
      push_write(KIND_RGB, 0, clamp_byte(r), clamp_byte(g), clamp_byte(b), 1'b1);
      return;
    end
    w = clamp_size(cur_width, DEF_MAX_WIDTH);
    h = clamp_size(cur_height, DEF_MAX_HEIGHT);
    ysize = w * h;
    y = ((66 * p + 129 * q + 25 * s + 128) >>> 8) + 16;
    has_chroma = (pos_row % 2 == 0) && (pos_column % 2 == 0);
    push_write(KIND_LUMA, luma_offset, clamp_byte(y), 8'd0, 8'd0, !has_chroma);
    if (has_chroma) begin
      u = ((-38 * p - 74 * q + 112 * s + 128) >>> 8) + 128;
      v = ((112 * p - 94 * q - 18 * s + 128) >>> 8) + 128;
      if (cur_layout == LAYOUT_NV21) begin
        vaddr = ysize + (pos_row / 2) * w + pos_column;
        uaddr = vaddr + 1;
      end else begin
        idx = (pos_row / 2) * (w / 2) + pos_column / 2;
        uaddr = ysize + idx;
        vaddr = ysize + ysize / 4 + idx;
      end
      push_write(KIND_V, vaddr, clamp_byte(v), 8'd0, 8'd0, 1'b0);
      push_write(KIND_U, uaddr, clamp_byte(u), 8'd0, 8'd0, 1'b1);
    end
    // Counters are not cleared on a size change, so the compare is >= rather than ==.
    pos_column++;
    luma_offset = luma_offset + 1'b1;
    if (pos_column >= w) begin
      pos_column = 0;
      pos_row++;
      if (pos_row >= h) begin
        pos_row = 0;
        luma_offset = '0;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t ns: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_write();
    frame_write_t w;
    if (expected_writes.size() == 0) begin
      report_mismatch("unexpected transaction, kind", out_kind, 0);
      return;
    end
    w = expected_writes.pop_front();
    if (out_kind !== w.kind) report_mismatch("kind", out_kind, w.kind);
    if (out_byte_address !== w.addr) report_mismatch("byte_address", out_byte_address, w.addr);
    if (out_value_a !== w.val_a) report_mismatch("value_a", out_value_a, w.val_a);
    if (out_value_b !== w.val_b) report_mismatch("value_b", out_value_b, w.val_b);
    if (out_value_c !== w.val_c) report_mismatch("value_c", out_value_c, w.val_c);
    if (out_last !== w.last) report_mismatch("last", out_last, w.last);
  endtask

  // All handshakes are observed here, on pre-edge values.
  always @(posedge clk) begin
    in_taken  <= rst_n && in_valid && in_ready;
    cfg_taken <= rst_n && cfg_valid && cfg_ready;
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   cur_width  = cfg_data;
        REG_FRAME_HEIGHT:  cur_height = cfg_data;
        REG_CHROMA_LAYOUT: cur_layout = cfg_data[0];
        default: ;
      endcase
    end
    if (rst_n && in_valid && in_ready) begin
      convert_pixel({in_mode, in_red_or_luma, in_green_or_u, in_blue_or_v});
      pixels_taken++;
    end
    if (rst_n && out_valid && out_ready) check_write();
  end

  // Sender: bursts of random length separated by random gaps.
  pixel_item_t next_pixel;
  int          burst_left = 0;
  int          gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        next_pixel = pixel_queue.pop_front();
        in_valid       <= 1'b1;
        in_mode        <= next_pixel.mode;
        in_red_or_luma <= next_pixel.ch0;
        in_green_or_u  <= next_pixel.ch1;
        in_blue_or_v   <= next_pixel.ch2;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: switches between steady, choppy and sluggish stretches.
  rx_style_e rx_style = RX_STEADY;
  int        rx_span  = 0;

  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_style = rx_style_e'($urandom_range(0, 2));
      rx_span  = $urandom_range(20, 80);
    end else begin
      rx_span--;
    end
    case (rx_style)
      RX_STEADY: out_ready <= 1'b1;
      RX_CHOPPY: out_ready <= ($urandom_range(0, 3) != 0);
      default:   out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  function automatic void add_pixel(input logic mode, input logic [BYTE_W-1:0] a,
                                    input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] c);
    pixel_queue.push_back({mode, a, b, c});
    pixels_queued++;
  endfunction

  function automatic void add_random_pixels(input int n);
    for (int i = 0; i < n; i++) begin
      add_pixel(($urandom_range(0, 4) == 0) ? MODE_TO_RGB : MODE_TO_YUV,
                rand_byte(), rand_byte(), rand_byte());
    end
  endfunction

  task automatic wait_idle();
    while (pixels_taken != pixels_queued || expected_writes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] width, height;
    logic             layout;
    int               count;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Field extremes in both directions, under the reset frame setup.
    add_pixel(MODE_TO_YUV, 8'd0, 8'd0, 8'd0);
    add_pixel(MODE_TO_YUV, 8'd255, 8'd255, 8'd255);
    add_pixel(MODE_TO_YUV, 8'd255, 8'd0, 8'd0);
    add_pixel(MODE_TO_YUV, 8'd0, 8'd255, 8'd0);
    add_pixel(MODE_TO_YUV, 8'd0, 8'd0, 8'd255);
    add_pixel(MODE_TO_YUV, 8'd255, 8'd0, 8'd255);
    add_pixel(MODE_TO_YUV, 8'd128, 8'd128, 8'd128);
    add_pixel(MODE_TO_RGB, 8'd0, 8'd0, 8'd0);
    add_pixel(MODE_TO_RGB, 8'd255, 8'd255, 8'd255);
    add_pixel(MODE_TO_RGB, 8'd16, 8'd128, 8'd128);
    add_pixel(MODE_TO_RGB, 8'd235, 8'd128, 8'd128);
    add_pixel(MODE_TO_RGB, 8'd255, 8'd0, 8'd255);
    add_pixel(MODE_TO_RGB, 8'd0, 8'd255, 8'd0);
    add_pixel(MODE_TO_RGB, 8'd128, 8'd255, 8'd0);
    add_pixel(MODE_TO_RGB, 8'd128, 8'd0, 8'd255);
    add_random_pixels(10);

    // Each setup leaves the raster position where it stopped, so later phases
    // start mid frame, some with counters at or beyond the new size.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin width = 13'd2;    height = 13'd2;    layout = LAYOUT_NV21; count = 30; end
        1:       begin width = 13'd4;    height = 13'd4;    layout = LAYOUT_I420; count = 40; end
        2:       begin width = 13'd0;    height = 13'd1;    layout = LAYOUT_I420; count = 16; end
        3:       begin width = 13'd3;    height = 13'd5;    layout = LAYOUT_NV21; count = 30; end
        4:       begin width = 13'd8191; height = 13'd8191; layout = LAYOUT_I420; count = 20; end
        5:       begin width = 13'd6;    height = 13'd4;    layout = LAYOUT_NV21; count = 40; end
        6:       begin width = 13'd4096; height = 13'd2;    layout = LAYOUT_NV21; count = 20; end
        7:       begin width = 13'd2;    height = 13'd4096; layout = LAYOUT_I420; count = 40; end
        8:       begin width = 13'd5;    height = 13'd3;    layout = LAYOUT_I420; count = 30; end
        default: begin width = 13'd10;   height = 13'd6;    layout = LAYOUT_NV21; count = 34; end
      endcase
      wait_idle();
      write_reg(REG_FRAME_WIDTH, width);
      write_reg(REG_FRAME_HEIGHT, height);
      write_reg(REG_CHROMA_LAYOUT, {{(CFG_W-1){1'b0}}, layout});
      add_random_pixels(count);
    end

    wait_idle();
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
